>>> rtl/ceq_pkg.sv
// ----------------------------------------------------------------------------
// ceq_pkg
// Shared widths, reset values, register indexes and debounce lengths for the
// charge end qualifier.
// ----------------------------------------------------------------------------
package ceq_pkg;

    // Field widths
    localparam int unsigned SOC_W   = 10;
    localparam int unsigned CUR_W   = 16;
    localparam int unsigned VOLT_W  = 16;
    localparam int unsigned TEMP_W  = 8;
    localparam int unsigned FAULT_W = 8;

    // Configuration port widths
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Consecutive hits before a condition fires
    localparam int unsigned LONG_HITS  = 6;
    localparam int unsigned SHORT_HITS = 4;

    // Register reset values
    localparam logic [SOC_W-1:0]  SOC_FULL_RST  = 10'd998;
    localparam logic [CUR_W-1:0]  END_CUR_RST   = 16'd30;
    localparam logic [VOLT_W-1:0] CELL_VOLT_RST = 16'd36500;
    localparam logic [TEMP_W-1:0] TEMP_HIGH_RST = 8'd95;
    localparam logic [TEMP_W-1:0] TEMP_LOW_RST  = 8'd40;

    // Fault level that forces an immediate stop
    localparam logic [FAULT_W-1:0] FAULT_STOP = 8'd1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOC_FULL  = 3'd0,
        CFG_END_CUR   = 3'd1,
        CFG_CELL_VOLT = 3'd2,
        CFG_TEMP_HIGH = 3'd3,
        CFG_TEMP_LOW  = 3'd4
    } cfg_index_t;

    // One battery sample as held in the input register
    typedef struct packed {
        logic [SOC_W-1:0]   state_of_charge;
        logic [CUR_W-1:0]   end_current;
        logic [VOLT_W-1:0]  max_cell_voltage;
        logic [TEMP_W-1:0]  highest_temp;
        logic [TEMP_W-1:0]  lowest_temp;
        logic [FAULT_W-1:0] bms_fault_level;
        logic [FAULT_W-1:0] charger_fault_level;
    } sample_t;

    // Control between the top level and a debounce counter
    typedef struct packed {
        logic advance;
        logic enable;
        logic hit;
    } deb_ctrl_t;

endpackage

>>> rtl/ceq_ifs.sv
// ----------------------------------------------------------------------------
// ceq_ifs
// Valid/ready channels of the charge end qualifier: sample, result and
// configuration write.
// ----------------------------------------------------------------------------
interface ceq_sample_if
    import ceq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SOC_W-1:0]   state_of_charge;
    logic [CUR_W-1:0]   end_current;
    logic [VOLT_W-1:0]  max_cell_voltage;
    logic [TEMP_W-1:0]  highest_temp;
    logic [TEMP_W-1:0]  lowest_temp;
    logic [FAULT_W-1:0] bms_fault_level;
    logic [FAULT_W-1:0] charger_fault_level;

    modport source (
        output valid, state_of_charge, end_current, max_cell_voltage,
               highest_temp, lowest_temp, bms_fault_level, charger_fault_level,
        input  ready
    );
    modport sink (
        input  valid, state_of_charge, end_current, max_cell_voltage,
               highest_temp, lowest_temp, bms_fault_level, charger_fault_level,
        output ready
    );
endinterface

interface ceq_result_if;
    logic valid;
    logic ready;
    logic stop_charge;

    modport source (output valid, stop_charge, input ready);
    modport sink   (input valid, stop_charge, output ready);
endinterface

interface ceq_cfg_if
    import ceq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ceq_debounce.sv
// ----------------------------------------------------------------------------
// ceq_debounce
// Consecutive-hit counter for one stop condition. Fires on the Need-th hit
// in a row, then restarts from zero. Holds when not evaluated.
// ----------------------------------------------------------------------------
module ceq_debounce
    import ceq_pkg::*;
#(
    parameter int unsigned Need = LONG_HITS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  deb_ctrl_t ctrl,
    output logic      fire
);

    localparam int unsigned CntW = (Need > 2) ? $clog2(Need) : 1;

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic [CntW:0]   count_inc;

    // Work out the hit count including this sample
    always_comb
    begin
        count_inc = {1'b0, count_reg} + {{CntW{1'b0}}, 1'b1};
        fire      = ctrl.enable && ctrl.hit && (count_inc >= (CntW+1)'(Need));
        if (!ctrl.hit || fire)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_inc[CntW-1:0];
        end
    end

    // Advance only when this condition is evaluated for a moving beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.advance && ctrl.enable)
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/charge_end_qualifier.sv
// ----------------------------------------------------------------------------
// charge_end_qualifier
// End-of-charge decision: five debounced stop conditions in priority order
// plus an immediate stop on a fault level of one.
// Pipeline: input register, then result register after one level of compare
//   and counter logic.
// Throughput: one sample per cycle; a stalled result holds one further
//   sample in the input register before sample.ready drops.
// Reset: clears valids and counters, loads thresholds with their defaults.
// ----------------------------------------------------------------------------
module charge_end_qualifier
    import ceq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    ceq_sample_if.sink   sample,
    ceq_result_if.source result,
    ceq_cfg_if.sink      cfg
);

    logic [SOC_W-1:0]  soc_full_level_reg;
    logic [CUR_W-1:0]  end_current_limit_reg;
    logic [VOLT_W-1:0] cell_volt_limit_reg;
    logic [TEMP_W-1:0] temp_high_limit_reg;
    logic [TEMP_W-1:0] temp_low_limit_reg;

    logic    in_valid_reg;
    sample_t in_reg;
    logic    out_valid_reg;
    logic    stop_reg;

    logic      advance;
    logic      stop_next;
    logic      fault_stop;
    logic [4:0] hit;
    logic [4:0] en;
    logic [4:0] fire;
    deb_ctrl_t  deb_ctrl [5];

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soc_full_level_reg    <= SOC_FULL_RST;
            end_current_limit_reg <= END_CUR_RST;
            cell_volt_limit_reg   <= CELL_VOLT_RST;
            temp_high_limit_reg   <= TEMP_HIGH_RST;
            temp_low_limit_reg    <= TEMP_LOW_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_SOC_FULL:  soc_full_level_reg    <= cfg.data[SOC_W-1:0];
                CFG_END_CUR:   end_current_limit_reg <= cfg.data[CUR_W-1:0];
                CFG_CELL_VOLT: cell_volt_limit_reg   <= cfg.data[VOLT_W-1:0];
                CFG_TEMP_HIGH: temp_high_limit_reg   <= cfg.data[TEMP_W-1:0];
                CFG_TEMP_LOW:  temp_low_limit_reg    <= cfg.data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Move the held sample on whenever the result register is free or drains
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    // Capture a sample beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_reg.state_of_charge     <= sample.state_of_charge;
            in_reg.end_current         <= sample.end_current;
            in_reg.max_cell_voltage    <= sample.max_cell_voltage;
            in_reg.highest_temp        <= sample.highest_temp;
            in_reg.lowest_temp         <= sample.lowest_temp;
            in_reg.bms_fault_level     <= sample.bms_fault_level;
            in_reg.charger_fault_level <= sample.charger_fault_level;
        end
    end

    // Compare against thresholds; a fired condition masks all later ones
    always_comb
    begin
        hit[0] = in_reg.state_of_charge >= soc_full_level_reg;
        hit[1] = in_reg.end_current < end_current_limit_reg;
        hit[2] = in_reg.max_cell_voltage > cell_volt_limit_reg;
        hit[3] = in_reg.highest_temp > temp_high_limit_reg;
        hit[4] = in_reg.lowest_temp < temp_low_limit_reg;

        en[0] = 1'b1;
        en[1] = en[0] && !fire[0];
        en[2] = en[1] && !fire[1];
        en[3] = en[2] && !fire[2];
        en[4] = en[3] && !fire[3];

        for (int i = 0; i < 5; i++)
        begin
            deb_ctrl[i].advance = advance;
            deb_ctrl[i].enable  = en[i];
            deb_ctrl[i].hit     = hit[i];
        end

        fault_stop = (in_reg.bms_fault_level == FAULT_STOP)
                  || (in_reg.charger_fault_level == FAULT_STOP);
        stop_next  = (|fire) || fault_stop;
    end

    ceq_debounce #(.Need(LONG_HITS)) u_soc_full (
        .clk(clk), .rst_n(rst_n), .ctrl(deb_ctrl[0]), .fire(fire[0])
    );
    ceq_debounce #(.Need(LONG_HITS)) u_low_current (
        .clk(clk), .rst_n(rst_n), .ctrl(deb_ctrl[1]), .fire(fire[1])
    );
    ceq_debounce #(.Need(SHORT_HITS)) u_over_volt (
        .clk(clk), .rst_n(rst_n), .ctrl(deb_ctrl[2]), .fire(fire[2])
    );
    ceq_debounce #(.Need(SHORT_HITS)) u_over_temp (
        .clk(clk), .rst_n(rst_n), .ctrl(deb_ctrl[3]), .fire(fire[3])
    );
    ceq_debounce #(.Need(SHORT_HITS)) u_under_temp (
        .clk(clk), .rst_n(rst_n), .ctrl(deb_ctrl[4]), .fire(fire[4])
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stop_reg <= stop_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.stop_charge = stop_reg;

endmodule

>>> rtl/ceq_checker.sv
// ----------------------------------------------------------------------------
// ceq_checker
// Port-level checks on the charge end qualifier: pipeline timing, fault
// stop and result hold under stall.
// ----------------------------------------------------------------------------
module ceq_checker
    import ceq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [FAULT_W-1:0] bms_fault_level,
    input logic               out_valid,
    input logic               out_ready,
    input logic               stop_charge
);

    logic in_beat;

    assign in_beat = in_valid && in_ready;

    // An empty result register never blocks a sample
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready
    ) else $error("sample blocked while result register empty");

    // Every sample beat shows a valid result after the input and result registers
    a_result_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_beat |-> ##2 out_valid
    ) else $error("no result two cycles after sample beat");

    // A battery fault level of one stops charging for that sample
    a_fault_stop: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_beat && bms_fault_level == FAULT_STOP) ##1 (!out_valid || out_ready)
            |=> (out_valid && stop_charge)
    ) else $error("fault level one did not stop charging");

    // Hold a stalled result
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(stop_charge))
    ) else $error("stalled result changed");

endmodule

bind charge_end_qualifier ceq_checker u_ceq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sample.valid),
    .in_ready        (sample.ready),
    .bms_fault_level (sample.bms_fault_level),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .stop_charge     (result.stop_charge)
);
